// File: src/rbbr_pkg.sv
// Shared types, constants and helpers for the random-below-bound reducer.
package rbbr_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam logic [2:0] TOP_BYTES = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SKIP,
        ST_GATHER,
        ST_CHECK,
        ST_MOD,
        ST_EMIT,
        ST_FAIL
    } t_state;

    // one-hot of the highest set bit of a byte
    function automatic logic [BYTE_W-1:0] msb_onehot8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            if (v[b]) begin
                r    = '0;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // byte k of a word, k = 0 is the least significant byte
    function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] k);
        logic [BYTE_W-1:0] r;
        case (k)
            2'd0: r = w[7:0];
            2'd1: r = w[15:8];
            2'd2: r = w[23:16];
            2'd3: r = w[31:24];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

// File: src/random_below_bound_reducer.sv
// Random value below a big-endian bound: byte stores, scan, serial modulo, byte emission.
// Loading: one transaction per cycle in the load state into two registered-read byte memories.
// After the last byte: bound scan (repeated below the top word when set-msb empties it),
// a bit-serial remainder, then n result bytes.
// Source failure: a single failure result after the last byte; a bad bound fails after its scan.
// Reset is synchronous, active low, and clears control state; the byte stores are not cleared.
module random_below_bound_reducer #(
    parameter int MAX_BYTES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rbbr_pkg::BYTE_W-1:0]  i_bound_byte,
    input  logic [rbbr_pkg::BYTE_W-1:0]  i_rand_byte,
    input  logic [rbbr_pkg::WORD_W-1:0]  i_rand_word,
    input  logic                         i_random_ok,
    input  logic                         i_last_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rbbr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_ok,
    output logic                         o_last_out
);
    import rbbr_pkg::*;

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = ($clog2(MAX_BYTES + 1) < 3) ? 3 : $clog2(MAX_BYTES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BYTES);

    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [CW-1:0]     r_count, n_count;
    logic              r_rfail, n_rfail;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_p, n_p;
    logic [2:0]        r_nb, n_nb;
    logic [WORD_W-1:0] r_top, n_top;
    logic [WORD_W-1:0] r_hmask, n_hmask;
    logic [WORD_W-1:0] r_rmask, n_rmask;
    logic [CW-1:0]     r_mp, n_mp;
    logic [2:0]        r_mnb, n_mnb;
    logic              r_second, n_second;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_or, n_or;
    logic [WORD_W-1:0] r_res, n_res;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_ook, n_ook;
    logic              r_olast, n_olast;

    logic [BYTE_W-1:0] bound_mem [MAX_BYTES];
    logic [BYTE_W-1:0] rand_mem  [MAX_BYTES];
    logic [BYTE_W-1:0] r_bound_q;
    logic [BYTE_W-1:0] r_rand_q;

    logic              in_acc;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     cnt_inc;
    logic              out_free;
    logic              emit_last;
    logic [WORD_W-1:0] top_x;
    logic              msb_pass;
    logic              msb_empty;
    logic              mod_start;
    logic [WORD_W-1:0] divisor;
    logic              mod_done;
    logic [WORD_W-1:0] mod_rem;
    logic              cfg_wr;

    logic [CW-1:0]     word_end;
    logic [CW-1:0]     mask_end;
    logic [CW-1:0]     k_w;
    logic [CW-1:0]     k_m;
    logic              in_word;
    logic              in_mask;
    logic [BYTE_W-1:0] emit_byte;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_mode};
    assign n_mode = cfg_wr ? pwdata[0] : r_mode;

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = in_acc && (r_count < MAX_CNT);
    assign wr_addr    = r_count[AW-1:0];
    assign rd_addr    = n_idx[AW-1:0];
    assign cnt_inc    = r_count + CW'(1);
    assign out_free   = !r_ovalid || i_out_ready;
    assign emit_last  = (r_idx == r_n - CW'(1));
    assign top_x      = r_top ^ r_hmask;
    assign msb_pass   = r_mode && !r_second;
    assign msb_empty  = msb_pass && (top_x == '0);
    assign mod_start  = (r_state == ST_CHECK) && !msb_empty;
    assign divisor    = msb_pass ? top_x : r_top;

    // result byte selection for the current emit index
    assign word_end  = r_p + CW'(r_nb);
    assign mask_end  = r_mp + CW'(r_mnb);
    assign k_w       = word_end - CW'(1) - r_idx;
    assign k_m       = mask_end - CW'(1) - r_idx;
    assign in_word   = (r_idx >= r_p) && (r_idx < word_end);
    assign in_mask   = r_second && (r_idx >= r_mp) && (r_idx < mask_end);

    always_comb begin
        if (in_word) begin
            emit_byte = word_byte(r_res, k_w[1:0]);
        end else if (in_mask) begin
            emit_byte = word_byte(r_rmask, k_m[1:0]);
        end else if (r_idx < r_p) begin
            emit_byte = '0;
        end else begin
            emit_byte = r_rand_q;
        end
    end

    rbbr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_word),
        .i_divisor  (divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_last_byte) begin
                    n_state = (r_rfail || !i_random_ok) ? ST_FAIL : ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (r_idx == r_n) begin
                    n_state = ST_FAIL;
                end else if (r_bound_q != '0) begin
                    n_state = ST_GATHER;
                end
            end
            ST_GATHER: begin
                if (r_nb == TOP_BYTES || r_idx == r_n) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = msb_empty ? ST_SKIP : ST_MOD;
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // datapath next values
    always_comb begin
        n_count  = r_count;
        n_rfail  = r_rfail;
        n_n      = r_n;
        n_idx    = r_idx;
        n_p      = r_p;
        n_nb     = r_nb;
        n_top    = r_top;
        n_hmask  = r_hmask;
        n_rmask  = r_rmask;
        n_mp     = r_mp;
        n_mnb    = r_mnb;
        n_second = r_second;
        n_word   = r_word;
        n_or     = r_or;
        n_res    = r_res;
        case (r_state)
            ST_LOAD: begin
                n_idx = '0;
                if (in_acc) begin
                    if (wr_en) begin
                        n_count = cnt_inc;
                    end
                    if (!i_random_ok) begin
                        n_rfail = 1'b1;
                    end
                    if (i_last_byte) begin
                        n_n      = wr_en ? cnt_inc : r_count;
                        n_word   = i_rand_word;
                        n_count  = '0;
                        n_rfail  = 1'b0;
                        n_second = 1'b0;
                    end
                end
            end
            ST_SKIP: begin
                if (r_idx != r_n) begin
                    n_idx = r_idx + CW'(1);
                    if (r_bound_q != '0) begin
                        n_p     = r_idx;
                        n_top   = {{(WORD_W-BYTE_W){1'b0}}, r_bound_q};
                        n_hmask = {{(WORD_W-BYTE_W){1'b0}}, msb_onehot8(r_bound_q)};
                        n_nb    = 3'd1;
                    end
                end
            end
            ST_GATHER: begin
                if (!(r_nb == TOP_BYTES || r_idx == r_n)) begin
                    n_top   = {r_top[WORD_W-BYTE_W-1:0], r_bound_q};
                    n_hmask = {r_hmask[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    n_nb    = r_nb + 3'd1;
                    n_idx   = r_idx + CW'(1);
                end
            end
            ST_CHECK: begin
                if (msb_empty) begin
                    // top word was a lone bit: it becomes mask bytes, rescan below it
                    n_rmask  = r_hmask;
                    n_mp     = r_p;
                    n_mnb    = r_nb;
                    n_second = 1'b1;
                end else begin
                    n_or  = msb_pass ? r_hmask : '0;
                    n_idx = '0;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_res = mod_rem | r_or;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_idx = emit_last ? '0 : r_idx + CW'(1);
                end
            end
            ST_FAIL: begin
                n_idx = '0;
            end
            default: n_idx = '0;
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid && !i_out_ready;
        n_obyte  = r_obyte;
        n_ook    = r_ook;
        n_olast  = r_olast;
        case (r_state)
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = emit_byte;
                    n_ook    = 1'b1;
                    n_olast  = emit_last;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = '0;
                    n_ook    = 1'b0;
                    n_olast  = 1'b1;
                end
            end
            default: begin
                n_obyte = r_obyte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_mode   <= 1'b0;
            r_count  <= '0;
            r_rfail  <= 1'b0;
            r_idx    <= '0;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
            r_word   <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_rfail  <= n_rfail;
            r_idx    <= n_idx;
            r_second <= n_second;
            r_ovalid <= n_ovalid;
            r_word   <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_p     <= n_p;
        r_nb    <= n_nb;
        r_top   <= n_top;
        r_hmask <= n_hmask;
        r_rmask <= n_rmask;
        r_mp    <= n_mp;
        r_mnb   <= n_mnb;
        r_or    <= n_or;
        r_res   <= n_res;
        r_obyte <= n_obyte;
        r_ook   <= n_ook;
        r_olast <= n_olast;
    end

    // byte stores; read address follows the next index, same-address write is forwarded
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            bound_mem[wr_addr] <= i_bound_byte;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_bound_q <= i_bound_byte;
        end else begin
            r_bound_q <= bound_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            rand_mem[wr_addr] <= i_rand_byte;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_rand_q <= i_rand_byte;
        end else begin
            r_rand_q <= rand_mem[rd_addr];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_ok        = r_ook;
    assign o_last_out  = r_olast;

    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_last_out && o_out_byte == '0))
        else $error("failure result is not a single zero byte");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == ST_MOD))
        else $error("remainder finished outside the modulo phase");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx < r_n))
        else $error("emit index ran past the byte count");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("byte count exceeds store depth");

endmodule

// File: src/rbbr_mod.sv
// Bit-serial 32-bit remainder unit, one dividend bit per cycle.
module rbbr_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rbbr_pkg::WORD_W-1:0]  i_dividend,
    input  logic [rbbr_pkg::WORD_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [rbbr_pkg::WORD_W-1:0]  o_rem
);
    import rbbr_pkg::*;

    localparam int SW = $clog2(WORD_W);
    localparam logic [SW-1:0] LAST_STEP = SW'(WORD_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SW-1:0]     r_cnt, n_cnt;
    logic [WORD_W-1:0] r_q, n_q;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_div, n_div;

    logic [WORD_W:0]   sh;
    logic [WORD_W:0]   diff;
    logic              ge;

    assign sh   = {r_rem, r_q[WORD_W-1]};
    assign diff = sh - {1'b0, r_div};
    assign ge   = (sh >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
            n_q   = {r_q[WORD_W-2:0], 1'b0};
            n_cnt = r_cnt + SW'(1);
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: tb/rbbr_checker.sv
// Transaction monitor, result predictor and scoreboard for the random-below-bound reducer.
module rbbr_checker #(
    parameter int         MAX_BYTES    = 64,
    parameter logic [2:0] MSB_REG_ADDR = 3'd0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    input  logic                         i_in_valid,
    input  logic                         o_in_ready,
    input  logic [rbbr_pkg::BYTE_W-1:0]  i_bound_byte,
    input  logic [rbbr_pkg::BYTE_W-1:0]  i_rand_byte,
    input  logic [rbbr_pkg::WORD_W-1:0]  i_rand_word,
    input  logic                         i_random_ok,
    input  logic                         i_last_byte,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic [rbbr_pkg::BYTE_W-1:0]  o_out_byte,
    input  logic                         o_ok,
    input  logic                         o_last_out,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbbr_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              ok;
        logic              last;
    } t_result_beat;

    logic [BYTE_W-1:0] bound_mem [MAX_BYTES];
    logic [BYTE_W-1:0] rand_mem  [MAX_BYTES];
    int                byte_cnt   = 0;
    bit                src_failed = 1'b0;
    bit                msb_mode   = 1'b0;
    int                fail_total = 0;
    int                pending_now = 0;
    t_result_beat      expected_results [$];

    assign o_fail_count = fail_total;
    assign o_pending    = pending_now;

    function automatic void log_error(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    // Bound complete: work out the result bytes of the run and queue them.
    function automatic void close_run(input logic [WORD_W-1:0] rword);
        logic [BYTE_W-1:0] res [MAX_BYTES];
        t_result_beat      beat;
        int                n, p, nb, nxt, hb;
        logic [WORD_W-1:0] top, msk, word;
        bit                bad;
        n          = byte_cnt;
        bad        = src_failed;
        byte_cnt   = 0;
        src_failed = 1'b0;
        p          = 0;
        while (p < n && bound_mem[p] == '0) begin
            res[p] = '0;
            p++;
        end
        if (p == n) begin
            bad = 1'b1;
        end
        if (!bad) begin
            for (int i = p; i < n; i++) begin
                res[i] = rand_mem[i];
            end
            top = '0;
            nb  = 0;
            while (nb < 4 && p + nb < n) begin
                top = {top[WORD_W-BYTE_W-1:0], bound_mem[p+nb]};
                nb++;
            end
            msk = '0;
            if (msb_mode) begin
                hb = 0;
                for (int b = 0; b < WORD_W; b++) begin
                    if (top[b]) begin
                        hb = b;
                    end
                end
                msk = 32'd1 << hb;
                top = top ^ msk;
                // top word emptied: its bytes carry the mask, next nonzero bytes take over
                if (top == '0) begin
                    nxt = p + nb;
                    while (nb > 0) begin
                        res[p+nb-1] = msk[BYTE_W-1:0];
                        msk = msk >> BYTE_W;
                        nb--;
                    end
                    msk = '0;
                    p   = nxt;
                    while (p < n && bound_mem[p] == '0) begin
                        res[p] = '0;
                        p++;
                    end
                    if (p == n) begin
                        bad = 1'b1;
                    end else begin
                        while (nb < 4 && p + nb < n) begin
                            top = {top[WORD_W-BYTE_W-1:0], bound_mem[p+nb]};
                            nb++;
                        end
                    end
                end
            end
            if (!bad) begin
                word = rword;
                if (top != '0 && word >= top) begin
                    word = word % top;
                end
                word = word | msk;
                while (nb > 0) begin
                    res[p+nb-1] = word[BYTE_W-1:0];
                    word = word >> BYTE_W;
                    nb--;
                end
            end
        end
        if (bad) begin
            beat.value = '0;
            beat.ok    = 1'b0;
            beat.last  = 1'b1;
            expected_results.push_back(beat);
        end else begin
            for (int i = 0; i < n; i++) begin
                beat.value = res[i];
                beat.ok    = 1'b1;
                beat.last  = (i == n - 1);
                expected_results.push_back(beat);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_result_beat want;
        if (!i_rst_n) begin
            byte_cnt   = 0;
            src_failed = 1'b0;
            msb_mode   = 1'b0;
            expected_results.delete();
        end else begin
            // results first, so a result cannot match what this same edge loads
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    log_error($sformatf("unexpected result: byte %02h ok %0b last %0b",
                                        o_out_byte, o_ok, o_last_out));
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_byte !== want.value || o_ok !== want.ok ||
                        o_last_out !== want.last) begin
                        log_error($sformatf({"result mismatch: expected byte %02h ok %0b ",
                                             "last %0b, got byte %02h ok %0b last %0b"},
                                            want.value, want.ok, want.last,
                                            o_out_byte, o_ok, o_last_out));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (byte_cnt < MAX_BYTES) begin
                    bound_mem[byte_cnt] = i_bound_byte;
                    rand_mem[byte_cnt]  = i_rand_byte;
                    byte_cnt++;
                end
                if (!i_random_ok) begin
                    src_failed = 1'b1;
                end
                if (i_last_byte) begin
                    close_run(i_rand_word);
                end
            end
            if (psel && penable && pwrite && pready && paddr == MSB_REG_ADDR) begin
                msb_mode = pwdata[0];
            end
        end
        pending_now = expected_results.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the random-below-bound reducer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbbr_pkg::*;

    localparam int         MAX_BYTES    = 64;
    localparam logic [2:0] ADDR_SET_MSB = 3'd0;
    localparam int         RANDOM_ITEMS = 250;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_bound_byte = '0;
    logic [BYTE_W-1:0] i_rand_byte  = '0;
    logic [WORD_W-1:0] i_rand_word  = '0;
    logic              i_random_ok  = 1'b1;
    logic              i_last_byte  = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_ok;
    logic              o_last_out;

    int                fail_count;
    int                pending;
    int                burst_left = 0;
    bit                gapless    = 1'b0;
    int                items_sent = 0;
    logic [31:0]       stall_tick = '0;
    logic [BYTE_W-1:0] run_bytes [$];

    random_below_bound_reducer #(.MAX_BYTES(MAX_BYTES)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bound_byte (i_bound_byte),
        .i_rand_byte  (i_rand_byte),
        .i_rand_word  (i_rand_word),
        .i_random_ok  (i_random_ok),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_ok         (o_ok),
        .o_last_out   (o_last_out)
    );

    rbbr_checker #(.MAX_BYTES(MAX_BYTES), .MSB_REG_ADDR(ADDR_SET_MSB)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bound_byte (i_bound_byte),
        .i_rand_byte  (i_rand_byte),
        .i_rand_word  (i_rand_word),
        .i_random_ok  (i_random_ok),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_ok         (o_ok),
        .o_last_out   (o_last_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // sink backpressure: cycles through always-ready, coin-flip, periodic and sparse stalls
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[9:8])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_ready <= (stall_tick[3:0] < 4'd3);
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] bnd, input logic [WORD_W-1:0] rword,
                             input logic ok_flag, input logic last_flag);
        int gap;
        if (burst_left == 0) begin
            gap = gapless ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid   <= 1'b1;
        i_bound_byte <= bnd;
        i_rand_byte  <= 8'($urandom_range(0, 255));
        i_rand_word  <= last_flag ? rword : $urandom();
        i_random_ok  <= ok_flag;
        i_last_byte  <= last_flag;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // sends run_bytes as one bound; bad_idx marks the byte with a random-source failure
    task automatic send_run(input logic [WORD_W-1:0] rword, input int bad_idx);
        for (int i = 0; i < run_bytes.size(); i++) begin
            send_byte(run_bytes[i], rword, i != bad_idx, i == run_bytes.size() - 1);
        end
    endtask

    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic build_run(input int len);
        int                zeros, kind;
        logic [BYTE_W-1:0] b;
        run_bytes.delete();
        zeros = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : 0;
        kind  = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
            if (i < zeros) begin
                b = '0;
            end else if (kind == 0 && i == zeros) begin
                b = 8'h01 << $urandom_range(0, 7);
            end else if (kind == 0) begin
                b = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            end else if (kind == 1) begin
                b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            run_bytes.push_back(b);
        end
    endtask

    initial begin
        int          len, bad, phase_mark, run_idx, stop_at;
        bit          next_mode;
        logic [31:0] rw;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_write(ADDR_SET_MSB, 32'd0);

        // zero bounds, extreme bytes, leading zeros, word below top, source failure
        run_bytes = {8'h00};
        send_run($urandom(), -1);
        run_bytes = {8'h00, 8'h00, 8'h00};
        send_run($urandom(), -1);
        run_bytes = {8'hFF};
        send_run(32'hFFFF_FFFF, -1);
        run_bytes = {8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        send_run(32'hFFFF_FFFE, -1);
        run_bytes = {8'h05, 8'h10};
        send_run($urandom(), 0);
        run_bytes = {8'h00, 8'h00, 8'h01, 8'h00};
        send_run(32'h0000_0042, -1);

        // set-msb: power-of-two bounds fail, emptied top word moves to later bytes
        drain_outputs();
        apb_write(ADDR_SET_MSB, 32'd1);
        run_bytes = {8'h80};
        send_run($urandom(), -1);
        run_bytes = {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07};
        send_run(32'hDEAD_BEEF, -1);
        run_bytes = {8'h01, 8'h00};
        send_run($urandom(), -1);
        run_bytes = {8'hFF, 8'hEE};
        send_run(32'h0, -1);

        drain_outputs();
        apb_write(ADDR_SET_MSB, 32'd0);
        next_mode  = 1'b1;
        phase_mark = items_sent;
        run_idx    = 0;
        stop_at    = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if (items_sent - phase_mark > 60) begin
                drain_outputs();
                apb_write(ADDR_SET_MSB, {31'd0, next_mode});
                next_mode  = ~next_mode;
                gapless    = ~gapless;
                phase_mark = items_sent;
            end
            if (run_idx == 6) begin
                len = MAX_BYTES;
            end else if (run_idx == 20) begin
                len = MAX_BYTES + $urandom_range(1, 6);   // overflow: extra bytes dropped
            end else if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(9, 24);
            end else begin
                len = $urandom_range(1, 8);
            end
            build_run(len);
            bad = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : -1;
            case ($urandom_range(0, 4))
                0: rw = $urandom_range(0, 255);
                1: rw = 32'hFFFF_FFFF;
                2: rw = 32'h0;
                default: rw = $urandom();
            endcase
            send_run(rw, bad);
            run_idx++;
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/rbbr_pkg.sv
src/rbbr_mod.sv
src/random_below_bound_reducer.sv
tb/rbbr_checker.sv
tb/tb.sv
